FILE: rtl/csp_pkg.sv
// csp_pkg: shared widths, defaults, register indexes and the command struct
// for the capped simplex projection block; no dependencies
package csp_pkg;

  // field widths
  localparam int VALUE_W   = 32;
  localparam int TARGET_W  = 25;
  localparam int CAP_W     = 25;
  localparam int TOL_W     = 16;
  localparam int WEIGHT_W  = 25;
  localparam int INDEX_W   = 6;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int BOUND_W   = 34;

  // parameter defaults
  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_BISECT_STEPS = 128;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(16777216);
  localparam logic [CAP_W-1:0]    CAP_RST    = CAP_W'(16777216);
  localparam logic [TOL_W-1:0]    TOL_RST    = TOL_W'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic store;   // take an input item
    logic init;    // load the bisection bounds
    logic mid;     // take the midpoint, clear the sum
    logic rd;      // read one stored element into the pipeline
    logic emit;    // the read feeds a result item
    logic update;  // move one bound to the midpoint
    logic check;   // evaluate the ok flag
    logic clear;   // forget the vector
  } cmd_t;

endpackage

FILE: rtl/csp_ctrl.sv
// csp_ctrl: sequencer for load, bisection sweeps and result emission
// depends on csp_pkg
module csp_ctrl #(
  parameter int MAX_ELEMENTS = 64,
  parameter int BISECT_STEPS = 128,
  parameter int CW           = $clog2(MAX_ELEMENTS + 1),
  parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          last_i,
  output logic          busy_o,
  input  logic [CW-1:0] count_i,
  input  logic          pipe_busy_i,
  output csp_pkg::cmd_t cmd_o,
  output logic [AW-1:0] rd_addr_o
);
  import csp_pkg::*;

  localparam int KW = $clog2(BISECT_STEPS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INIT   = 4'd1;
  localparam logic [3:0] ST_MID    = 4'd2;
  localparam logic [3:0] ST_SWEEP  = 4'd3;
  localparam logic [3:0] ST_DRAIN  = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_EMIT   = 4'd6;
  localparam logic [3:0] ST_EDRAIN = 4'd7;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, i_inc;
  logic [KW-1:0] k_q, k_d;
  cmd_t          cmd;

  assign i_inc = i_q + CW'(1);

  // next state and commands
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    k_d     = k_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd.store = 1'b1;
          if (last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        k_d      = '0;
        state_d  = ST_MID;
      end
      ST_MID: begin
        cmd.mid = 1'b1;
        i_d     = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.rd = 1'b1;
        i_d    = i_inc;
        if (i_inc == count_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          if (k_q == KW'(BISECT_STEPS)) begin
            state_d = ST_CHECK;
          end else begin
            cmd.update = 1'b1;
            k_d        = k_q + KW'(1);
            state_d    = ST_MID;
          end
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        i_d       = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.rd   = 1'b1;
        cmd.emit = 1'b1;
        i_d      = i_inc;
        if (i_inc == count_i) begin
          state_d = ST_EDRAIN;
        end
      end
      ST_EDRAIN: begin
        if (!pipe_busy_i) begin
          cmd.clear = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign cmd_o     = cmd;
  assign rd_addr_o = i_q[AW-1:0];

  // closing item starts the solve
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("closing item did not start the solve");

  // reads stay inside the stored vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> (i_q < count_i))
    else $error("read beyond the stored vector");

  // idle only with an empty read pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pipe_busy_i)
    else $error("idle with items still in the pipeline");

endmodule

FILE: rtl/csp_datapath.sv
// csp_datapath: configuration registers, element store, min/max tracking,
// bisection bounds, clamp pipeline and sum; depends on csp_pkg
module csp_datapath #(
  parameter int MAX_ELEMENTS = 64,
  parameter int CW           = $clog2(MAX_ELEMENTS + 1),
  parameter int AW           = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [csp_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [csp_pkg::VALUE_W-1:0]   value_i,
  input  csp_pkg::cmd_t                        cmd_i,
  input  logic [AW-1:0]                        rd_addr_i,
  output logic [CW-1:0]                        count_o,
  output logic                                 pipe_busy_o,
  output logic                                 strobe_o,
  output logic [csp_pkg::WEIGHT_W-1:0]         weight_o,
  output logic [csp_pkg::INDEX_W-1:0]          index_o,
  output logic                                 ok_o,
  output logic                                 last_out_o
);
  import csp_pkg::*;

  localparam int DIFF_W = BOUND_W + 1;
  localparam int SUM_W  = CAP_W + CW;

  // configuration
  logic [TARGET_W-1:0] target_q;
  logic [CAP_W-1:0]    cap_q;
  logic [TOL_W-1:0]    tol_q;

  // vector state
  logic [VALUE_W-1:0]        mem [MAX_ELEMENTS];
  logic [CW-1:0]             count_q;
  logic signed [VALUE_W-1:0] min_q, max_q;
  logic                      wr_en;

  // bisection state
  logic signed [BOUND_W-1:0] low_q, high_q, shift_q;
  logic signed [DIFF_W-1:0]  mid_sum;
  logic [SUM_W-1:0]          sum_q;

  // read and clamp pipeline
  logic [VALUE_W-1:0]       rdata_q;
  logic                     rvld_q, remit_q;
  logic [AW-1:0]            ridx_q;
  logic                     cvld_q, cemit_q;
  logic [AW-1:0]            cidx_q;
  logic [WEIGHT_W-1:0]      clamp_q, clamp_d;
  logic signed [DIFF_W-1:0] diff;

  // ok evaluation
  logic                 ok_q, ok_d;
  logic [SUM_W-1:0]     cap_total, miss, target_ext;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      cap_q    <= CAP_RST;
      tol_q    <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i[TARGET_W-1:0];
        CFG_CAP:    cap_q    <= cfg_data_i[CAP_W-1:0];
        CFG_TOL:    tol_q    <= cfg_data_i[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  // element store, excess items dropped
  assign wr_en = cmd_i.store && (count_q < CW'(MAX_ELEMENTS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= value_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // count and running extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= {1'b0, {(VALUE_W-1){1'b1}}};
      max_q   <= {1'b1, {(VALUE_W-1){1'b0}}};
    end else if (cmd_i.clear) begin
      count_q <= '0;
      min_q   <= {1'b0, {(VALUE_W-1){1'b1}}};
      max_q   <= {1'b1, {(VALUE_W-1){1'b0}}};
    end else if (wr_en) begin
      count_q <= count_q + CW'(1);
      if (value_i < min_q) begin
        min_q <= value_i;
      end
      if (value_i > max_q) begin
        max_q <= value_i;
      end
    end
  end

  // bounds: start at min - cap and max, then close in on the shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (cmd_i.init) begin
      low_q  <= {{(BOUND_W-VALUE_W){min_q[VALUE_W-1]}}, min_q}
                - {{(BOUND_W-CAP_W){1'b0}}, cap_q};
      high_q <= {{(BOUND_W-VALUE_W){max_q[VALUE_W-1]}}, max_q};
    end else if (cmd_i.update) begin
      if (sum_q > target_ext) begin
        low_q <= shift_q;
      end else begin
        high_q <= shift_q;
      end
    end
  end

  // midpoint rounded toward minus infinity
  assign mid_sum = {low_q[BOUND_W-1], low_q} + {high_q[BOUND_W-1], high_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mid) begin
      shift_q <= mid_sum[DIFF_W-1:1];
    end
  end

  // clamp of value minus shift into zero to cap
  assign diff = {{(DIFF_W-VALUE_W){rdata_q[VALUE_W-1]}}, rdata_q}
                - {shift_q[BOUND_W-1], shift_q};

  always_comb begin
    if (diff[DIFF_W-1]) begin
      clamp_d = '0;
    end else if (diff[BOUND_W-1:0] > {{(BOUND_W-CAP_W){1'b0}}, cap_q}) begin
      clamp_d = cap_q;
    end else begin
      clamp_d = diff[WEIGHT_W-1:0];
    end
  end

  // pipeline valid and tag bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q  <= 1'b0;
      remit_q <= 1'b0;
      cvld_q  <= 1'b0;
      cemit_q <= 1'b0;
    end else begin
      rvld_q  <= cmd_i.rd;
      remit_q <= cmd_i.emit;
      cvld_q  <= rvld_q;
      cemit_q <= remit_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    ridx_q  <= rd_addr_i;
    cidx_q  <= ridx_q;
    clamp_q <= clamp_d;
  end

  // clamped sum over one sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.mid) begin
      sum_q <= '0;
    end else if (cvld_q && !cemit_q) begin
      sum_q <= sum_q + SUM_W'(clamp_q);
    end
  end

  // ok flag: nonzero target and cap, feasible, sum within tolerance
  assign target_ext = SUM_W'(target_q);
  assign cap_total  = SUM_W'(cap_q) * SUM_W'(count_q);
  assign miss       = (sum_q >= target_ext) ? (sum_q - target_ext)
                                            : (target_ext - sum_q);

  always_comb begin
    ok_d = 1'b1;
    if ((target_q == '0) || (cap_q == '0)) begin
      ok_d = 1'b0;
    end
    if (target_ext > cap_total) begin
      ok_d = 1'b0;
    end
    if (miss > SUM_W'(tol_q)) begin
      ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ok_q <= ok_d;
    end
  end

  // result items
  assign count_o     = count_q;
  assign pipe_busy_o = rvld_q | cvld_q;
  assign strobe_o    = cvld_q & cemit_q;
  assign weight_o    = ok_q ? clamp_q : '0;
  assign index_o     = INDEX_W'(cidx_q);
  assign ok_o        = ok_q;
  assign last_out_o  = ((CW'(cidx_q) + CW'(1)) == count_q);

  // bisection interval never inverts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= high_q)
    else $error("bisection bounds crossed");

  // result weights never exceed the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (weight_o <= cap_q))
    else $error("weight above cap");

  // results only come from a stored vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (count_q != '0))
    else $error("result item with empty vector");

endmodule

FILE: rtl/capped_simplex_projection.sv
// capped_simplex_projection: top level, controller plus datapath
// for n stored elements, the bisection sweeps over the vector run after the closing
// item and before the first result, then one result per cycle for each of the n elements
// a closing item keeps busy high through the sweeps and the result emission; other
// items are taken one per cycle while busy is low
// results cannot be stalled; async active-low reset, target 1.0, cap 1.0, tolerance 64
module capped_simplex_projection #(
  parameter int MAX_ELEMENTS = csp_pkg::DEF_MAX_ELEMENTS,
  parameter int BISECT_STEPS = csp_pkg::DEF_BISECT_STEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [csp_pkg::VALUE_W-1:0] value_i,
  input  logic                               last_i,
  input  logic                               cfg_we_i,
  input  logic [csp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [csp_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                               strobe_o,
  output logic [csp_pkg::WEIGHT_W-1:0]       weight_o,
  output logic [csp_pkg::INDEX_W-1:0]        index_o,
  output logic                               ok_o,
  output logic                               last_out_o
);
  import csp_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  cmd_t          cmd;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic          pipe_busy;

  // sequencer
  csp_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BISECT_STEPS (BISECT_STEPS),
    .CW           (CW),
    .AW           (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_i      (last_i),
    .busy_o      (busy),
    .count_i     (count),
    .pipe_busy_i (pipe_busy),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // store, bounds and clamp pipeline
  csp_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .CW           (CW),
    .AW           (AW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .count_o     (count),
    .pipe_busy_o (pipe_busy),
    .strobe_o    (strobe_o),
    .weight_o    (weight_o),
    .index_o     (index_o),
    .ok_o        (ok_o),
    .last_out_o  (last_out_o)
  );

endmodule
